FILE: src/crc16fb_pkg.sv
// ----------------------------------------------------------------------------
// crc16fb_pkg
// Shared types, framing constants and the byte-wide CRC-16/ARC update.
// ----------------------------------------------------------------------------
package crc16fb_pkg;

	// largest payload length; longer requests are clipped to this
	localparam int MAX_PAYLOAD = 74;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int CRC_W  = 16;

	localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h55;
	localparam logic [BYTE_W-1:0] FLAG_BYTE     = 8'h7E;
	localparam logic [CRC_W-1:0]  CRC_POLY_REFL = 16'hA001;
	localparam logic [CRC_W-1:0]  CRC_INIT      = 16'h0000;

	// output slots of one job, in stream order
	localparam int NUM_SLOTS = 7;
	localparam int SLOT_W    = 3;
	localparam logic [SLOT_W-1:0] SLOT_PRE    = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_SFLAG  = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_LEN    = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_DATA   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_CRC_HI = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_CRC_LO = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_EFLAG  = 3'd6;

	// one item's worth of output, handed from core to serializer
	typedef struct packed {
		logic              hdr;
		logic [LEN_W-1:0]  len;
		logic              dat;
		logic [BYTE_W-1:0] data;
		logic              trl;
		logic [CRC_W-1:0]  crc;
	} job_t;

	// fold one byte into the reflected crc, lsb first
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: src/crc16fb_item_if.sv
// ----------------------------------------------------------------------------
// crc16fb_item_if
// Input channel: one payload byte with its frame-opening fields per word.
// ----------------------------------------------------------------------------
interface crc16fb_item_if import crc16fb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic              first_of_frame;
	logic [LEN_W-1:0]  frame_length;

	modport source (output valid, output payload_byte, output first_of_frame,
		output frame_length, input ready);
	modport sink (input valid, input payload_byte, input first_of_frame,
		input frame_length, output ready);
endinterface

FILE: src/crc16fb_byte_if.sv
// ----------------------------------------------------------------------------
// crc16fb_byte_if
// Output channel: one byte of the framed stream per word.
// ----------------------------------------------------------------------------
interface crc16fb_byte_if import crc16fb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              end_of_frame;
	logic              run_last;

	modport source (output valid, output frame_byte, output end_of_frame,
		output run_last, input ready);
	modport sink (input valid, input frame_byte, input end_of_frame,
		input run_last, output ready);
endinterface

FILE: src/crc16fb_core.sv
// ----------------------------------------------------------------------------
// crc16fb_core
// Input register, frame state and crc update; builds one job per item that opens or continues a frame.
// ----------------------------------------------------------------------------
module crc16fb_core import crc16fb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	crc16fb_item_if.sink item,
	output logic         job_valid,
	output job_t         job,
	input  logic         job_ready
);

	logic              v_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              first_s1;
	logic [LEN_W-1:0]  len_s1;

	logic [CRC_W-1:0] crc_q;
	logic [LEN_W-1:0] left_q;
	logic             open_q;

	job_t             job_c;
	logic             nonempty;
	logic             consume;
	logic [LEN_W-1:0] len_sat;
	logic [CRC_W-1:0] crc_n;
	logic [LEN_W-1:0] left_n;
	logic             open_n;

	// frame decision for the registered word
	always_comb begin
		len_sat  = (int'(len_s1) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len_s1;
		job_c    = '0;
		nonempty = 1'b0;
		crc_n    = crc_q;
		left_n   = left_q;
		open_n   = open_q;
		if (first_s1) begin
			nonempty  = 1'b1;
			job_c.hdr = 1'b1;
			job_c.len = len_sat;
			if (len_sat == '0) begin
				crc_n     = CRC_INIT;
				left_n    = '0;
				open_n    = 1'b0;
				job_c.trl = 1'b1;
			end else begin
				crc_n     = crc_fold(CRC_INIT, data_s1);
				left_n    = len_sat - LEN_W'(1);
				open_n    = (left_n != '0);
				job_c.dat = 1'b1;
				job_c.trl = (left_n == '0);
			end
		end else if (open_q) begin
			nonempty  = 1'b1;
			crc_n     = crc_fold(crc_q, data_s1);
			left_n    = left_q - LEN_W'(1);
			open_n    = (left_n != '0);
			job_c.dat = 1'b1;
			job_c.trl = (left_n == '0);
		end
		job_c.data = data_s1;
		job_c.crc  = crc_n;
	end

	// ignored words drain without waiting on the serializer
	assign consume    = v_s1 && (job_ready || !nonempty);
	assign item.ready = !v_s1 || consume;
	assign job_valid  = v_s1 && nonempty;
	assign job        = job_c;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			data_s1  <= item.payload_byte;
			first_s1 <= item.first_of_frame;
			len_s1   <= item.frame_length;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			left_q <= '0;
			open_q <= 1'b0;
		end else if (consume) begin
			crc_q  <= crc_n;
			left_q <= left_n;
			open_q <= open_n;
		end
	end

	// an open frame always expects at least one more byte
	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (left_q != '0))
		else $error("frame open with no bytes left");

	// a trailer always closes the frame
	a_trl_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && job_valid && job.trl) |=> !open_q)
		else $error("frame still open after trailer");

	// a held word stays in the input register
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !consume) |=> v_s1)
		else $error("held input word lost");

endmodule

FILE: src/crc16fb_ser.sv
// ----------------------------------------------------------------------------
// crc16fb_ser
// Output serializer: holds one job and sends its bytes one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module crc16fb_ser import crc16fb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  job_t           job,
	output logic           job_ready,
	crc16fb_byte_if.source result
);

	job_t                 job_q;
	logic                 busy_q;
	logic [SLOT_W-1:0]    pos_q;

	logic [NUM_SLOTS-1:0] en_q;
	logic [NUM_SLOTS-1:0] en_in;
	logic [NUM_SLOTS-1:0] rest;
	logic [SLOT_W-1:0]    pos_nxt;
	logic [SLOT_W-1:0]    pos_first;
	logic                 fire;
	logic                 last;

	// lowest enabled slot in a mask
	function automatic logic [SLOT_W-1:0] low_slot(input logic [NUM_SLOTS-1:0] m);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

	assign en_q  = {job_q.trl, job_q.trl, job_q.trl, job_q.dat,
		job_q.hdr, job_q.hdr, job_q.hdr};
	assign en_in = {job.trl, job.trl, job.trl, job.dat, job.hdr, job.hdr, job.hdr};

	// slots still to go after the current one
	assign rest      = en_q & ~NUM_SLOTS'((8'd2 << pos_q) - 8'd1);
	assign last      = (rest == '0);
	assign pos_nxt   = low_slot(rest);
	assign pos_first = low_slot(en_in);

	assign fire      = result.valid && result.ready;
	assign job_ready = !busy_q || (fire && last);

	// byte select for the current slot
	always_comb begin
		case (pos_q)
			SLOT_PRE:    result.frame_byte = PREAMBLE_BYTE;
			SLOT_SFLAG:  result.frame_byte = FLAG_BYTE;
			SLOT_LEN:    result.frame_byte = {1'b0, job_q.len};
			SLOT_DATA:   result.frame_byte = job_q.data;
			SLOT_CRC_HI: result.frame_byte = job_q.crc[CRC_W-1:BYTE_W];
			SLOT_CRC_LO: result.frame_byte = job_q.crc[BYTE_W-1:0];
			default:     result.frame_byte = FLAG_BYTE;
		endcase
	end

	assign result.valid        = busy_q;
	assign result.end_of_frame = (pos_q == SLOT_EFLAG);
	assign result.run_last     = last;

	// job register and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= SLOT_PRE;
		end else if (job_ready) begin
			busy_q <= job_valid;
			if (job_valid) begin
				pos_q <= pos_first;
			end
		end else if (fire) begin
			pos_q <= pos_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_q <= job;
		end
	end

	// the pointer always sits on a slot the job uses
	a_pos_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> en_q[pos_q])
		else $error("serializer on an unused slot");

	// the closing flag is the last word of its item
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && result.end_of_frame) |-> result.run_last)
		else $error("end flag not last word of item");

	// a stalled output word stays offered
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> result.valid)
		else $error("output word dropped while stalled");

endmodule

FILE: src/crc16_frame_builder_top.sv
// ----------------------------------------------------------------------------
// crc16_frame_builder_top
// Byte framer with preamble, start flag, length, CRC-16/ARC trailer and end flag.
// ----------------------------------------------------------------------------
// Each input word carries one payload byte; the word that opens a frame also
// carries the length (clipped to MAX_PAYLOAD). The output stream is one byte
// per word: 0x55, 0x7E, length, the payload bytes, CRC high, CRC low, 0x7E.
// Output moves one byte per cycle unless result.ready stalls it; the
// serializer sets the rate: a word yielding n bytes (1 for a middle payload
// byte, up to 7 for a one-byte frame) holds the output for all n, so
// unstalled middle payload bytes flow at one word per cycle. A new input
// word is taken while earlier bytes wait; it goes via input and job registers.
// Non-opening words outside a frame are dropped without output.
module crc16_frame_builder_top import crc16fb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	crc16fb_item_if.sink   item,
	crc16fb_byte_if.source result
);

	logic job_valid;
	logic job_ready;
	job_t job;

	crc16fb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	crc16fb_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.result    (result)
	);

endmodule
